[design/single_float_add_sub_core_defines.svh]
// Assertion macros for the single-precision add/sub core.
`ifndef SINGLE_FLOAT_ADD_SUB_CORE_DEFINES_SVH
`define SINGLE_FLOAT_ADD_SUB_CORE_DEFINES_SVH
// Property p must hold at every edge out of reset.
`define SFA_ASSERT(label, p, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);
// Property p must hold at every edge, also in reset.
`define SFA_ASSERT_ALWAYS(label, p, msg) \
  label: assert property (@(posedge clk) (p)) else $error(msg);
`endif

[design/sfa_pkg.sv]
// Package: constants, types and helpers of the single-precision add/sub core.
package sfa_pkg;
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] QNAN_WORD = 32'h7FC0_0000;
  localparam logic [7:0] EXP_MAXF = 8'hFF;

  typedef enum logic [1:0] {
    CLS_FINITE  = 2'd0,
    CLS_SPECIAL = 2'd1
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] special;
    logic        lsign;
    logic        rsign;
    logic [7:0]  lexp;
    logic [7:0]  rexp;
    logic [23:0] lman;
    logic [23:0] rman;
  } front_item_t;

  function automatic logic [24:0] shift_round(input logic [24:0] v, input logic [4:0] n);
    logic [49:0] w;
    logic [24:0] q;
    logic [24:0] low;
    logic [24:0] half;
    w = {v, 25'd0} >> n;
    q = w[49:25];
    low = w[24:0];
    half = 25'h100_0000;
    if (n == 5'd0) begin
      q = v;
    end else if (low > half) begin
      q = q + 25'd1;
    end else if (low == half) begin
      q = q + {24'd0, q[0]};
    end
    return q;
  endfunction

  function automatic logic [4:0] lead_zeros(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction
endpackage

[design/sfa_if.sv]
// Valid/ready channel interfaces of the single-precision add/sub core.
interface sfa_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] left_operand;
  logic [31:0] right_operand;
  modport source (output valid, req_type, left_operand, right_operand, input ready);
  modport sink (input valid, req_type, left_operand, right_operand, output ready);
endinterface

interface sfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_value;
  modport source (output valid, sum_value, input ready);
  modport sink (input valid, sum_value, output ready);
endinterface

[design/single_float_add_sub_core.sv]
// Top level of the single-precision add/sub core.
// Usage: drive in_valid with req_type (0 add, 1 subtract) and two IEEE
// single words; a transfer happens when in_valid and in_ready are high.
// The result comes on out_sum_value with out_valid; it is taken when
// out_ready is high. The front end unpacks, handles NaN and infinity and
// aligns the smaller operand with round-to-nearest-even, then writes a
// two-entry queue. The back end adds or subtracts, normalizes with a
// leading-zero count and shifter, and registers the packed word.
// The input transfer writes the queue; the back end then loads the result
// into the output register and raises out_valid (queue plus output register).
// Throughput: one item per cycle while out_ready stays high.
// When the receiver stalls, the output register holds, the queue fills,
// and in_ready drops once the queue is full; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and output register.
module single_float_add_sub_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_left_operand,
  input  logic [31:0] in_right_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sum_value
);
  import sfa_pkg::*;
  sfa_in_if in_ch ();
  sfa_out_if out_ch ();
  front_item_t item;
  logic item_valid, item_ready;

  assign in_ch.valid = in_valid;
  assign in_ch.req_type = in_req_type;
  assign in_ch.left_operand = in_left_operand;
  assign in_ch.right_operand = in_right_operand;
  assign in_ready = in_ch.ready;
  assign out_valid = out_ch.valid;
  assign out_sum_value = out_ch.sum_value;
  assign out_ch.ready = out_ready;

  sfa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .item_valid(item_valid), .item_ready(item_ready), .item(item)
  );
  sfa_back u_back (
    .clk(clk), .rst_n(rst_n), .item_valid(item_valid),
    .item_ready(item_ready), .item(item), .out_ch(out_ch)
  );
endmodule

[design/sfa_front.sv]
// Front end: accept operands, classify specials, unpack and align.
module sfa_front (
  input  logic                clk,
  input  logic                rst_n,
  sfa_in_if.sink              in_ch,
  output logic                item_valid,
  input  logic                item_ready,
  output sfa_pkg::front_item_t item
);
  import sfa_pkg::*;
  logic [31:0] l, r;
  logic [7:0] lef, ref_e, dexp;
  logic [22:0] lf, rf;
  logic [23:0] lm, rm;
  logic [7:0] le, re, diff;
  logic [24:0] sh;
  logic [4:0] amt;
  front_item_t it;

  always_comb begin
    l = in_ch.left_operand;
    r = in_ch.right_operand ^ {in_ch.req_type, 31'd0};
    lef = l[30:23];
    ref_e = r[30:23];
    lf = l[22:0];
    rf = r[22:0];
    lm = {lef != 8'd0, lf};
    rm = {ref_e != 8'd0, rf};
    le = (lef == 8'd0) ? 8'd1 : lef;
    re = (ref_e == 8'd0) ? 8'd1 : ref_e;
    it = '0;
    it.lsign = l[31];
    it.rsign = r[31];
    it.cls = CLS_FINITE;
    it.special = '0;
    if (lef == EXP_MAXF) begin
      it.cls = CLS_SPECIAL;
      if (lf != 23'd0) it.special = l;
      else if (ref_e == EXP_MAXF) begin
        if (rf != 23'd0) it.special = r;
        else it.special = (l[31] == r[31]) ? r : QNAN_WORD;
      end else it.special = l;
    end else if (ref_e == EXP_MAXF) begin
      it.cls = CLS_SPECIAL;
      it.special = r;
    end
    diff = 8'd0;
    dexp = le;
    if (re > le) begin
      diff = re - le;
      dexp = re;
    end else if (le > re) begin
      diff = le - re;
    end
    amt = (diff > 8'd25) ? 5'd25 : diff[4:0];
    sh = shift_round({1'b0, (re > le) ? lm : rm}, amt);
    if (diff > 8'd24) sh = '0;
    it.lexp = dexp;
    it.rexp = dexp;
    it.lman = (re > le) ? sh[23:0] : lm;
    it.rman = (le > re) ? sh[23:0] : rm;
  end

  sfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_valid  (in_ch.valid),
    .wr_ready  (in_ch.ready),
    .wr_data   (it),
    .rd_valid  (item_valid),
    .rd_ready  (item_ready),
    .rd_data   (item)
  );
endmodule

[design/sfa_queue.sv]
// Short queue between the front and back ends.
module sfa_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  sfa_pkg::front_item_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output sfa_pkg::front_item_t rd_data
);
  import sfa_pkg::*;
  front_item_t mem_r [QueueDepth];
  logic wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'(QueueDepth);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_comb begin
    wp_nxt = wr ? !wp_r : wp_r;
    rp_nxt = rd ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

[design/sfa_back.sv]
// Back end: add or subtract magnitudes, normalize, round and pack.
module sfa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  sfa_pkg::front_item_t item,
  sfa_out_if.source            out_ch
);
  import sfa_pkg::*;
  logic [24:0] sum, rnd;
  logic sgn;
  logic [8:0] e, en;
  logic [4:0] lz, sh;
  logic [23:0] m;
  logic [31:0] res;
  logic valid_r;
  logic [31:0] data_r;

  always_comb begin
    sgn = item.lsign;
    if (item.lsign != item.rsign) begin
      if (item.lman > item.rman) sum = {1'b0, item.lman - item.rman};
      else begin
        sum = {1'b0, item.rman - item.lman};
        sgn = item.rsign;
      end
    end else sum = {1'b0, item.lman} + {1'b0, item.rman};
    e = {1'b0, item.lexp};
    rnd = shift_round(sum, 5'd1);
    lz = lead_zeros(sum[23:0]);
    sh = ({4'd0, lz} < e) ? lz : 5'(e - 9'd1);
    m = sum[23:0] << sh;
    en = e - {4'd0, sh};
    res = '0;
    if (item.cls == CLS_SPECIAL) res = item.special;
    else if (sum == 25'd0) res = '0;
    else if (sum[24]) begin
      en = e + 9'd1;
      if (en >= 9'd255) res = {sgn, 8'hFF, 23'd0};
      else res = {sgn, rnd[23] ? en[7:0] : 8'd0, rnd[22:0]};
    end else res = {sgn, m[23] ? en[7:0] : 8'd0, m[22:0]};
  end

  assign item_ready = !valid_r || out_ch.ready;
  assign out_ch.valid = valid_r;
  assign out_ch.sum_value = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (item_ready) valid_r <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) data_r <= res;
  end
endmodule

[design/sfa_checker.sv]
// Port checker for the single-precision add/sub core, with its bind.
`include "single_float_add_sub_core_defines.svh"
module sfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sum_value
);
  `SFA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_sum_value), "output dropped while stalled")
  `SFA_ASSERT(a_first_out, $past(!rst_n) |-> !out_valid, "output right after reset")
  `SFA_ASSERT(a_ready_free, out_ready && !out_valid |-> in_ready, "input blocked with empty output")
  `SFA_ASSERT(a_in_to_out, in_valid && in_ready && out_ready |=> ##1 out_valid, "result missing")
endmodule

bind single_float_add_sub_core sfa_checker u_sfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_sum_value(out_sum_value)
);

[bench/single_float_add_sub_core_tb.sv]
// Testbench for the single-precision add/sub core: directed table, then random checked ops.
`timescale 1ns / 1ps
module single_float_add_sub_core_tb;
  import sfa_pkg::*;

  localparam int RandomOps = 750;
  localparam int StallLimit = 5000;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_t;

  typedef struct {
    op_t         op;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic        known;
    logic [31:0] sum;
  } vector_t;

  logic clk;
  logic rst_n;

  sfa_in_if  req_ch ();
  sfa_out_if sum_ch ();

  single_float_add_sub_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req_ch.valid),
    .in_ready        (req_ch.ready),
    .in_req_type     (req_ch.req_type),
    .in_left_operand (req_ch.left_operand),
    .in_right_operand(req_ch.right_operand),
    .out_valid       (sum_ch.valid),
    .out_ready       (sum_ch.ready),
    .out_sum_value   (sum_ch.sum_value)
  );

  logic [31:0] sum_queue[$];
  int mismatches;
  int sums_seen;
  int idle_cycles;
  int sink_wait;
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [23:0] align_rne(logic [23:0] v, int n);
    logic [47:0] wide;
    logic [23:0] q;
    logic [23:0] low;
    logic [23:0] half;
    if (n == 0) return v;
    if (n > 24) return 24'd0;
    wide = {v, 24'd0} >> n;
    q = wide[47:24];
    low = wide[23:0];
    half = 24'h80_0000;
    if (low > half || (low == half && q[0])) q = q + 24'd1;
    return q;
  endfunction

  function automatic logic [31:0] fp_add_sub(op_t op, logic [31:0] lhs, logic [31:0] rhs_in);
    logic [31:0] rhs;
    logic [23:0] lman;
    logic [23:0] rman;
    logic [24:0] mag;
    logic        rsign;
    logic        dsign;
    int          lexp;
    int          rexp;
    int          dexp;
    rhs = rhs_in;
    if (op == OP_SUB) rhs[31] = ~rhs[31];
    if (lhs[30:23] == EXP_MAXF) begin
      if (lhs[22:0] != 0) return lhs;
      if (rhs[30:23] == EXP_MAXF) begin
        if (rhs[22:0] != 0) return rhs;
        return (lhs[31] == rhs[31]) ? rhs : QNAN_WORD;
      end
      return lhs;
    end
    if (rhs[30:23] == EXP_MAXF) return rhs;
    lman = {lhs[30:23] != 0, lhs[22:0]};
    rman = {rhs[30:23] != 0, rhs[22:0]};
    lexp = (lhs[30:23] == 0) ? -126 : int'(lhs[30:23]) - 127;
    rexp = (rhs[30:23] == 0) ? -126 : int'(rhs[30:23]) - 127;
    rsign = rhs[31];
    if (rexp > lexp) begin
      lman = align_rne(lman, rexp - lexp);
      dexp = rexp;
    end else begin
      rman = align_rne(rman, lexp - rexp);
      dexp = lexp;
    end
    if (lhs[31] != rsign) begin
      if (lman > rman) begin
        mag = lman - rman;
        dsign = lhs[31];
      end else begin
        mag = rman - lman;
        dsign = rsign;
      end
    end else begin
      mag = lman + rman;
      dsign = lhs[31];
    end
    if (mag == 0) return 32'd0;
    if (mag[24]) begin
      mag = mag[0] && mag[1] ? (mag >> 1) + 25'd1 : mag >> 1;
      dexp++;
      if (dexp + 127 >= 255) return {dsign, 8'hFF, 23'd0};
    end else begin
      while (!mag[23] && dexp > -126) begin
        mag = mag << 1;
        dexp--;
      end
    end
    return {dsign, mag[23] ? 8'(dexp + 127) : 8'd0, mag[22:0]};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic drop_valid();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_op(op_t op, logic [31:0] lhs, logic [31:0] rhs);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.left_operand <= lhs;
    req_ch.right_operand <= rhs;
    do @(posedge clk); while (!req_ch.ready);
    sum_queue.push_back(fp_add_sub(op, lhs, rhs));
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'hFF;
      1: w[30:23] = 8'h00;
      2: w[30:23] = 8'hFE;
      3: w[30:0] = 31'd0;
      default: w[30:23] = 8'(120 + $urandom_range(0, 15));
    endcase
    return w;
  endfunction

  vector_t directed[$] = '{
    '{OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_ADD, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{OP_SUB, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000},
    '{OP_ADD, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000},
    '{OP_ADD, 32'h7FC0_1234, 32'h3F80_0000, 1'b1, 32'h7FC0_1234},
    '{OP_SUB, 32'h7F80_0000, 32'h7FA0_0001, 1'b1, 32'hFFA0_0001},
    '{OP_ADD, 32'h7F80_0000, 32'h7F80_0000, 1'b1, 32'h7F80_0000},
    '{OP_SUB, 32'h7F80_0000, 32'h7F80_0000, 1'b1, 32'h7FC0_0000},
    '{OP_ADD, 32'hFF80_0000, 32'h4000_0000, 1'b1, 32'hFF80_0000},
    '{OP_SUB, 32'h4000_0000, 32'h7F80_0000, 1'b1, 32'hFF80_0000},
    '{OP_ADD, 32'h3F80_0000, 32'hFFC0_0000, 1'b1, 32'hFFC0_0000},
    '{OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},
    '{OP_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'hFF80_0000},
    '{OP_ADD, 32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0002},
    '{OP_ADD, 32'h007F_FFFF, 32'h0000_0001, 1'b1, 32'h0080_0000},
    '{OP_SUB, 32'h0080_0000, 32'h0000_0001, 1'b1, 32'h007F_FFFF},
    '{OP_ADD, 32'h3F80_0000, 32'h3380_0000, 1'b0, 32'h0},
    '{OP_ADD, 32'h3F80_0000, 32'h3300_0001, 1'b0, 32'h0},
    '{OP_ADD, 32'h4B80_0000, 32'h0000_0001, 1'b0, 32'h0},
    '{OP_SUB, 32'h3F80_0001, 32'h3F80_0000, 1'b0, 32'h0},
    '{OP_ADD, 32'h4B7F_FFFF, 32'h3F80_0000, 1'b0, 32'h0},
    '{OP_SUB, 32'hC040_0000, 32'h4120_0000, 1'b0, 32'h0},
    '{OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF}
  };

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = OP_ADD;
    req_ch.left_operand = '0;
    req_ch.right_operand = '0;
    mismatches = 0;
    sums_seen = 0;
    stim_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_op(directed[i].op, directed[i].lhs, directed[i].rhs);
      if (directed[i].known && sum_queue[$] !== directed[i].sum)
        report_mismatch("predictor table", sum_queue[$], directed[i].sum);
    end
    drop_valid();
    wait (sum_queue.size() == 0);
    for (int i = 0; i < RandomOps; i++) begin
      if (i == RandomOps / 2) begin
        drop_valid();
        wait (sum_queue.size() == 0);
      end
      send_op(op_t'($urandom_range(0, 1)), rand_float(), rand_float());
    end
    drop_valid();
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_wait = $urandom_range(0, 19);
      sum_ch.ready <= 1'b0;
    end else begin
      if (sum_ch.valid && sum_ch.ready) sink_wait = $urandom_range(0, 19);
      else if (sink_wait > 0) sink_wait--;
      sum_ch.ready <= (sink_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && sum_ch.valid && sum_ch.ready) begin
      sums_seen++;
      if (sum_queue.size() == 0) begin
        report_mismatch("unexpected sum_value", sum_ch.sum_value, 32'hx);
      end else begin
        if (sum_ch.sum_value !== sum_queue[0])
          report_mismatch("sum_value", sum_ch.sum_value, sum_queue[0]);
        void'(sum_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (sum_ch.valid && sum_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout with %0d sums pending", sum_queue.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done && sum_queue.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d directed and %0d random add/sub operations, %0d sums checked",
             directed.size(), RandomOps, sums_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
